// ----- sv/gmd_pkg.sv -----
package gmd_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int ENTRY_W  = ROW_W + COL_W;
	localparam int DIM_W    = 7;
	localparam int IDX_W    = ROW_W + DIM_W;

	localparam logic [7:0] CHAR_OPEN  = 8'd32;
	localparam logic [7:0] CHAR_START = 8'd77;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);
	localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
	localparam logic [DIM_W-1:0] ROWS_MAX  = DIM_W'(MAX_ROWS);
	localparam logic [DIM_W-1:0] COLS_MAX  = DIM_W'(MAX_COLS);

	typedef enum logic [0:0] {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CODE_WALL  = 2'd0,
		CODE_OPEN  = 2'd1,
		CODE_START = 2'd2
	} cell_code_t;

	typedef enum logic [1:0] {
		RES_FOUND    = 2'd0,
		RES_NO_PATH  = 2'd1,
		RES_NO_START = 2'd2
	} res_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_SWEEP,
		ST_PUSH_START,
		ST_POP,
		ST_CUR_IDX,
		ST_CUR_RD,
		ST_CUR_MARK,
		ST_NB_IDX,
		ST_NB_RD,
		ST_NB_EVAL,
		ST_PUSH_CUR,
		ST_PUSH_NB,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic search_init;
		logic sweep;
		logic push_start;
		logic pop;
		logic cur_latch;
		logic cur_mark;
		logic dir_clear;
		logic dir_next;
		logic nb_latch;
		logic push_cur;
		logic push_nb;
		logic out_load;
		res_t out_code;
	} gmd_cmd_t;

	typedef struct packed {
		logic start_ok;
		logic sweep_last;
		logic stack_empty;
		logic cur_exit;
		logic nb_inbounds;
		logic nb_open;
		logic dir_last;
		logic out_free;
	} gmd_stat_t;

endpackage

// ----- sv/gmd_ctrl.sv -----
module gmd_ctrl import gmd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  gmd_stat_t stat,
	output gmd_cmd_t  cmd
);

	state_t state_q, state_d;
	res_t   res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			res_q   <= RES_NO_PATH;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && in_last) state_d = ST_INIT;
			end
			ST_INIT: begin
				if (stat.start_ok) begin
					state_d = ST_SWEEP;
				end else begin
					res_d   = RES_NO_START;
					state_d = ST_RESULT;
				end
			end
			ST_SWEEP: begin
				if (stat.sweep_last) state_d = ST_PUSH_START;
			end
			ST_PUSH_START: state_d = ST_POP;
			ST_POP: begin
				if (stat.stack_empty) begin
					res_d   = RES_NO_PATH;
					state_d = ST_RESULT;
				end else begin
					state_d = ST_CUR_IDX;
				end
			end
			ST_CUR_IDX: state_d = ST_CUR_RD;
			ST_CUR_RD:  state_d = ST_CUR_MARK;
			ST_CUR_MARK: begin
				if (stat.cur_exit) begin
					res_d   = RES_FOUND;
					state_d = ST_RESULT;
				end else begin
					state_d = ST_NB_IDX;
				end
			end
			ST_NB_IDX: begin
				if (stat.nb_inbounds) state_d = ST_NB_RD;
				else if (stat.dir_last) state_d = ST_POP;
			end
			ST_NB_RD: state_d = ST_NB_EVAL;
			ST_NB_EVAL: begin
				if (stat.nb_open) state_d = ST_PUSH_CUR;
				else if (stat.dir_last) state_d = ST_POP;
				else state_d = ST_NB_IDX;
			end
			ST_PUSH_CUR: state_d = ST_PUSH_NB;
			ST_PUSH_NB:  state_d = ST_POP;
			ST_RESULT: begin
				if (stat.out_free) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.out_code = res_q;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_INIT:       cmd.search_init = stat.start_ok;
			ST_SWEEP:      cmd.sweep = 1'b1;
			ST_PUSH_START: cmd.push_start = 1'b1;
			ST_POP:        cmd.pop = !stat.stack_empty;
			ST_CUR_IDX:    cmd.cur_latch = 1'b1;
			ST_CUR_RD:     cmd.dir_clear = 1'b1;
			ST_CUR_MARK:   cmd.cur_mark = 1'b1;
			ST_NB_IDX: begin
				cmd.nb_latch = stat.nb_inbounds;
				cmd.dir_next = !stat.nb_inbounds && !stat.dir_last;
			end
			ST_NB_RD: ;
			ST_NB_EVAL:    cmd.dir_next = !stat.nb_open && !stat.dir_last;
			ST_PUSH_CUR:   cmd.push_cur = 1'b1;
			ST_PUSH_NB:    cmd.push_nb = 1'b1;
			ST_RESULT:     cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

endmodule

// ----- sv/gmd_datapath.sv -----
module gmd_datapath import gmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata,
	input  logic [7:0]       cell_char,
	input  gmd_cmd_t         cmd,
	output gmd_stat_t        stat,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [1:0]       out_status,
	output logic [CNT_W-1:0] out_steps
);

	logic [DIM_W-1:0]  rows_q, cols_q, rows_c, cols_c;
	logic [2*DIM_W-1:0] total_full;
	logic [CNT_W-1:0]  total;

	logic [CNT_W-1:0]  load_index_q;
	logic [ADDR_W-1:0] start_cell_q;
	logic              start_valid_q;

	logic [CNT_W-1:0]  sweep_cnt_q;
	logic [ROW_W-1:0]  div_q_q;
	logic [ADDR_W-1:0] div_rem_q;

	logic [CNT_W-1:0]  depth_q;
	logic [CNT_W-1:0]  visit_count_q;
	logic [ROW_W-1:0]  cur_r_q, nb_r_q, nr;
	logic [COL_W-1:0]  cur_c_q, nb_c_q, nc;
	logic              nb_inbounds;
	dir_t              dir_q;
	logic [ADDR_W-1:0] idx_q;

	logic [1:0]         grid_mem [CELLS];
	logic               vis_mem [CELLS];
	logic [ENTRY_W-1:0] stack_mem [CELLS];
	logic [1:0]         grid_rd_q;
	logic               vis_rd_q;
	logic               lt_q;
	logic [ENTRY_W-1:0] stack_rd_q;

	logic [ROW_W-1:0]  sel_r;
	logic [COL_W-1:0]  sel_c;
	logic [IDX_W-1:0]  idx_full;
	cell_code_t        load_code;
	logic              load_take;
	logic              push_en;
	logic [ENTRY_W-1:0] push_data;
	logic              first_visit;

	// Configuration registers and clamped geometry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_RESET;
			cols_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_NUM_ROWS: rows_q <= cfg_wdata;
				REG_NUM_COLS: cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		rows_c = rows_q;
		if (rows_q < DIM_MIN) rows_c = DIM_MIN;
		else if (rows_q > ROWS_MAX) rows_c = ROWS_MAX;
		cols_c = cols_q;
		if (cols_q < DIM_MIN) cols_c = DIM_MIN;
		else if (cols_q > COLS_MAX) cols_c = COLS_MAX;
	end

	assign total_full = {{DIM_W{1'b0}}, rows_c} * {{DIM_W{1'b0}}, cols_c};
	assign total      = total_full[CNT_W-1:0];

	always_comb begin
		load_code = CODE_WALL;
		if (cell_char == CHAR_OPEN) load_code = CODE_OPEN;
		else if (cell_char == CHAR_START) load_code = CODE_START;
	end

	assign load_take = cmd.load && (load_index_q < total);

	// Row/column to linear index, one multiply-add into idx_q.
	assign sel_r    = cmd.cur_latch ? stack_rd_q[ENTRY_W-1:COL_W] : nr;
	assign sel_c    = cmd.cur_latch ? stack_rd_q[COL_W-1:0] : nc;
	assign idx_full = ({{DIM_W{1'b0}}, sel_r} * {{ROW_W{1'b0}}, cols_c})
	                  + {{(IDX_W-COL_W){1'b0}}, sel_c};

	always_comb begin
		nr = cur_r_q;
		nc = cur_c_q;
		nb_inbounds = 1'b0;
		case (dir_q)
			DIR_RIGHT: begin
				nc = cur_c_q + COL_W'(1);
				nb_inbounds = ({1'b0, cur_c_q} + DIM_W'(1)) < cols_c;
			end
			DIR_DOWN: begin
				nr = cur_r_q + ROW_W'(1);
				nb_inbounds = ({1'b0, cur_r_q} + DIM_W'(1)) < rows_c;
			end
			DIR_LEFT: begin
				nc = cur_c_q - COL_W'(1);
				nb_inbounds = (cur_c_q != '0);
			end
			DIR_UP: begin
				nr = cur_r_q - ROW_W'(1);
				nb_inbounds = (cur_r_q != '0);
			end
			default: ;
		endcase
	end

	assign push_en     = (cmd.push_start || cmd.push_cur || cmd.push_nb)
	                     && (depth_q < CNT_W'(CELLS));
	assign first_visit = cmd.cur_mark && !vis_rd_q;

	always_comb begin
		push_data = {nb_r_q, nb_c_q};
		if (cmd.push_start) push_data = {div_q_q, div_rem_q[COL_W-1:0]};
		else if (cmd.push_cur) push_data = {cur_r_q, cur_c_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_index_q  <= '0;
			start_valid_q <= 1'b0;
			start_cell_q  <= '0;
			sweep_cnt_q   <= '0;
			depth_q       <= '0;
			visit_count_q <= '0;
			dir_q         <= DIR_RIGHT;
			out_valid     <= 1'b0;
		end else begin
			if (load_take) begin
				load_index_q <= load_index_q + CNT_W'(1);
				if (load_code == CODE_START) begin
					start_cell_q  <= load_index_q[ADDR_W-1:0];
					start_valid_q <= 1'b1;
				end
			end
			if (cmd.search_init) begin
				sweep_cnt_q   <= '0;
				depth_q       <= '0;
				visit_count_q <= '0;
			end
			if (cmd.sweep) sweep_cnt_q <= sweep_cnt_q + CNT_W'(1);
			if (push_en) depth_q <= depth_q + CNT_W'(1);
			if (cmd.pop) depth_q <= depth_q - CNT_W'(1);
			if (first_visit && (idx_q != start_cell_q))
				visit_count_q <= visit_count_q + CNT_W'(1);
			if (cmd.dir_clear) dir_q <= DIR_RIGHT;
			else if (cmd.dir_next) dir_q <= dir_t'(dir_q + 2'd1);
			if (cmd.out_load) begin
				out_valid     <= 1'b1;
				load_index_q  <= '0;
				start_valid_q <= 1'b0;
				start_cell_q  <= '0;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (cmd.search_init) begin
			div_q_q   <= '0;
			div_rem_q <= start_cell_q;
		end else if (cmd.sweep && ({1'b0, div_rem_q} >= {{(CNT_W-DIM_W){1'b0}}, cols_c})) begin
			div_q_q   <= div_q_q + ROW_W'(1);
			div_rem_q <= div_rem_q - {{(ADDR_W-DIM_W){1'b0}}, cols_c};
		end
		if (cmd.cur_latch) begin
			cur_r_q <= stack_rd_q[ENTRY_W-1:COL_W];
			cur_c_q <= stack_rd_q[COL_W-1:0];
		end
		if (cmd.nb_latch) begin
			nb_r_q <= nr;
			nb_c_q <= nc;
		end
		if (cmd.cur_latch || cmd.nb_latch) idx_q <= idx_full[ADDR_W-1:0];
		lt_q <= ({1'b0, idx_q} < load_index_q);
		if (cmd.out_load) begin
			out_status <= cmd.out_code;
			out_steps  <= (cmd.out_code == RES_NO_START) ? '0 : visit_count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_take) grid_mem[load_index_q[ADDR_W-1:0]] <= load_code;
		grid_rd_q <= grid_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) vis_mem[sweep_cnt_q[ADDR_W-1:0]] <= 1'b0;
		else if (first_visit) vis_mem[idx_q] <= 1'b1;
		vis_rd_q <= vis_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (push_en) stack_mem[depth_q[ADDR_W-1:0]] <= push_data;
		if (cmd.pop) stack_rd_q <= stack_mem[depth_q[ADDR_W-1:0] - ADDR_W'(1)];
	end

	assign stat.start_ok    = start_valid_q && ({1'b0, start_cell_q} < total);
	assign stat.sweep_last  = (sweep_cnt_q == total - CNT_W'(1));
	assign stat.stack_empty = (depth_q == '0);
	assign stat.cur_exit    = ({1'b0, cur_r_q} == rows_c - DIM_W'(2))
	                          && ({1'b0, cur_c_q} == cols_c - DIM_W'(1));
	assign stat.nb_inbounds = nb_inbounds;
	assign stat.nb_open     = lt_q && (grid_rd_q == CODE_OPEN) && !vis_rd_q;
	assign stat.dir_last    = (dir_q == DIR_UP);
	assign stat.out_free    = !out_valid || out_ready;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> depth_q != '0)
		else $error("pop from an empty stack");

	a_cur_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cur_mark |-> ({1'b0, idx_q} < total))
		else $error("current cell outside the grid");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_start |-> ({1'b0, div_rem_q} < {{(CNT_W-DIM_W){1'b0}}, cols_c}))
		else $error("start cell column not resolved");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

endmodule

// ----- sv/grid_maze_dfs_solver_unit.sv -----
// Operation: cells load at one transaction per cycle. After the tlast transaction the block
// checks the start, clears the visited map cell by cell and pushes the start; then it pops
// the stack, reads and marks the current cell, tries each neighbor in turn, pushes a
// current/neighbor pair when it finds an open one, and finally loads the result register.
// Throughput: one cell per cycle while loading; one maze at a time, tready low meanwhile.
// Reset (arst_n low, asynchronous): control state, counters and output valid clear,
// both dimension registers return to 64; the memories keep their contents.
module grid_maze_dfs_solver_unit import gmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// Configuration write port: index 0 is num_rows, index 1 is num_cols.
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata,
	// Input stream, one maze cell per transaction.
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [7:0] cell_char
	input  logic             s_axis_tlast,  // last_cell
	// Result stream, one transaction per search.
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata   // [1:0] status, [14:2] steps, [15] zero
);

	gmd_cmd_t         cmd;
	gmd_stat_t        stat;
	logic [1:0]       res_status;
	logic [CNT_W-1:0] res_steps;

	// The controller sequences loading, the visited-map sweep, and the search loop.
	// It only accepts cells in its load state, so tready is low during a search.
	gmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the grid, visited map and stack memories, the geometry
	// registers, and the output register that holds a result until it is taken.
	gmd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cell_char  (s_axis_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (res_status),
		.out_steps  (res_steps)
	);

	// Pack the result fields from the lowest bit up and pad to a whole byte.
	assign m_axis_tdata = {1'b0, res_steps, res_status};

endmodule

// ----- sim/tb_top.sv -----
module tb_top import gmd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// A wall character that is easy to recognize in the directed mazes.
	localparam logic [7:0] CHAR_WALL = "#";
	// Cycles that pass after the last result before a register is touched.
	localparam int SETTLE_CYCLES = 8;
	// Cycles that pass after the last result before the verdict.
	localparam int TAIL_CYCLES = 64;
	// Length of the long hold-off on the result side.
	localparam int LONG_HOLD = 600;
	// Amount of random stimulus: cells offered.
	localparam int RANDOM_CELLS = 340;

	typedef enum {
		MAZE_NORMAL,
		MAZE_NO_START,
		MAZE_TWO_STARTS,
		MAZE_SHORT,
		MAZE_OVERFULL
	} maze_kind_t;

	// One search outcome, as the result stream carries it.
	typedef struct packed {
		res_t        status;
		logic [12:0] steps;
	} outcome_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_index = 1'b0;
	logic [DIM_W-1:0] cfg_wdata = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = '0;  // [7:0] cell_char
	logic             s_axis_tlast = 1'b0;  // last_cell
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [15:0]      m_axis_tdata;  // [1:0] status, [14:2] steps, [15] zero

	// Mirror of the block: dimension registers, loaded grid and search scratch.
	logic [DIM_W-1:0] rows_reg = DIM_RESET;
	logic [DIM_W-1:0] cols_reg = DIM_RESET;
	cell_code_t       grid_mem [CELLS];
	bit               seen [CELLS];
	int               path [CELLS];
	int               load_cnt = 0;
	int               start_pos = 0;
	bit               start_ok = 1'b0;

	// Outcomes predicted but not yet seen on the result stream, oldest first.
	outcome_t outcomes_due [$];

	int  err_count = 0;
	int  cells_sent = 0;
	int  hold_request = 0;
	bit  sender_no_gaps = 1'b0;
	bit  sink_no_gaps = 1'b0;

	grid_maze_dfs_solver_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A register value below two or above the maximum saturates.
	function automatic int dim_in_use(input logic [DIM_W-1:0] raw, input int hi);
		if (raw < DIM_MIN)
			return int'(DIM_MIN);
		if (raw > hi)
			return hi;
		return int'(raw);
	endfunction

	// Most gaps are short, a few are long, and about half are none at all.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] wall_char();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(255));
		while (ch == CHAR_OPEN || ch == CHAR_START);
		return ch;
	endfunction

	// A dimension written to the register: now and then the extremes are written as
	// out-of-range values, which the block has to saturate.
	function automatic logic [DIM_W-1:0] encode_dim(input int dim);
		if (dim == DIM_MIN && $urandom_range(1))
			return DIM_W'($urandom_range(0, 1));
		if (dim == MAX_ROWS && $urandom_range(1))
			return DIM_W'($urandom_range(MAX_ROWS + 1, 127));
		return DIM_W'(dim);
	endfunction

	// Stores one accepted cell in the mirror. The cell flagged last then runs the
	// depth-first search over the mirror and queues the outcome it predicts.
	function automatic void mirror_cell(input logic [7:0] ch, input logic last);
		int       rows, cols, total, pos, r, c, nr, nc, nidx, depth, visits;
		outcome_t res;
		rows = dim_in_use(rows_reg, MAX_ROWS);
		cols = dim_in_use(cols_reg, MAX_COLS);
		total = rows * cols;
		// Cells beyond the grid in force are dropped, a start among them too.
		if (load_cnt < total) begin
			if (ch == CHAR_OPEN) begin
				grid_mem[load_cnt] = CODE_OPEN;
			end else if (ch == CHAR_START) begin
				grid_mem[load_cnt] = CODE_START;
				start_pos = load_cnt;
				start_ok = 1'b1;
			end else begin
				grid_mem[load_cnt] = CODE_WALL;
			end
			load_cnt++;
		end
		if (!last)
			return;

		foreach (seen[i])
			seen[i] = 1'b0;
		visits = 0;
		depth = 0;
		res.status = RES_NO_PATH;
		if (!start_ok || start_pos >= total) begin
			res.status = RES_NO_START;
		end else begin
			path[0] = start_pos;
			depth = 1;
			while (depth > 0) begin
				depth--;
				pos = path[depth];
				r = pos / cols;
				c = pos % cols;
				if (!seen[pos]) begin
					seen[pos] = 1'b1;
					if (pos != start_pos)
						visits++;
				end
				if (r == rows - 2 && c == cols - 1) begin
					res.status = RES_FOUND;
					break;
				end
				// First unvisited open neighbor wins; the current cell goes back on
				// the stack under it so that the search can return here later.
				for (int d = 0; d < 4; d++) begin
					nr = r;
					nc = c;
					case (dir_t'(d))
						DIR_RIGHT: nc = c + 1;
						DIR_DOWN:  nr = r + 1;
						DIR_LEFT:  nc = c - 1;
						DIR_UP:    nr = r - 1;
					endcase
					if (nr < 0 || nc < 0 || nr >= rows || nc >= cols)
						continue;
					nidx = nr * cols + nc;
					// Cells not loaded for this grid count as walls.
					if (nidx >= load_cnt || grid_mem[nidx] != CODE_OPEN || seen[nidx])
						continue;
					if (depth < CELLS) begin
						path[depth] = pos;
						depth++;
					end
					if (depth < CELLS) begin
						path[depth] = nidx;
						depth++;
					end
					break;
				end
			end
		end
		res.steps = (res.status == RES_NO_START) ? 13'd0 : 13'(visits);
		outcomes_due.push_back(res);
		load_cnt = 0;
		start_ok = 1'b0;
		start_pos = 0;
	endfunction

	// Offers one cell after a random gap and waits for its transaction. The valid is
	// lowered only when a gap follows, so back-to-back cells keep it high.
	task automatic send_cell(input logic [7:0] ch, input logic last);
		int gap;
		gap = sender_no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		cells_sent++;
		mirror_cell(ch, last);
	endtask

	// Stops offering cells and waits until every predicted outcome has arrived, then
	// lets the block settle so that a register write finds it idle.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the rows register and then the columns register, one write after the other.
	task automatic set_dims(input logic [DIM_W-1:0] rows_raw, input logic [DIM_W-1:0] cols_raw);
		cfg_we <= 1'b1;
		cfg_index <= REG_NUM_ROWS;
		cfg_wdata <= rows_raw;
		@(posedge clk);
		rows_reg = rows_raw;
		cfg_index <= REG_NUM_COLS;
		cfg_wdata <= cols_raw;
		@(posedge clk);
		cols_reg = cols_raw;
		cfg_we <= 1'b0;
	endtask

	// Builds a random maze of the given shape and sends it. Well-formed mazes hold one
	// start and, half of the time, a carved corridor to the exit; the other kinds break
	// the format on purpose.
	task automatic send_maze(input int rows, input int cols, input maze_kind_t kind);
		logic [7:0] cells [$];
		int         total, n, spos, r, c;
		total = rows * cols;
		n = total;
		if (kind == MAZE_SHORT)
			n = (total > 400) ? $urandom_range(40, 200) : $urandom_range(1, total - 1);
		for (int i = 0; i < n; i++)
			cells.push_back(($urandom_range(99) < 65) ? CHAR_OPEN : wall_char());
		spos = $urandom_range(n - 1);
		if (kind != MAZE_NO_START)
			cells[spos] = CHAR_START;
		if (kind == MAZE_TWO_STARTS)
			cells[$urandom_range(n - 1)] = CHAR_START;
		if (kind == MAZE_NORMAL && $urandom_range(1)) begin
			// Corridor along the start row to the last column, then down or up to
			// the exit row.
			r = spos / cols;
			c = spos % cols;
			while (c != cols - 1 || r != rows - 2) begin
				if (c != cols - 1)
					c++;
				else
					r += (r < rows - 2) ? 1 : -1;
				cells[r * cols + c] = CHAR_OPEN;
			end
		end
		if (kind == MAZE_OVERFULL) begin
			repeat ($urandom_range(1, 5)) begin
				case ($urandom_range(2))
					0: cells.push_back(CHAR_OPEN);
					1: cells.push_back(CHAR_START);
					default: cells.push_back(wall_char());
				endcase
			end
		end
		foreach (cells[i])
			send_cell(cells[i], i == cells.size() - 1);
	endtask

	// Dimensions as they come out of reset: a start with one open cell to its right,
	// and the rest of the large grid never loaded, so it reads as wall.
	task automatic test_reset_dims();
		send_cell(CHAR_START, 1'b0);
		send_cell(CHAR_OPEN, 1'b1);
		drain_results();
	endtask

	// A grid without any start, with the all-zero and all-one characters as walls.
	// The start of the previous grid must not carry over.
	task automatic test_no_start();
		set_dims(2, 2);
		send_cell(8'h00, 1'b0);
		send_cell(8'hFF, 1'b0);
		send_cell(CHAR_OPEN, 1'b0);
		send_cell(CHAR_OPEN, 1'b1);
		drain_results();
	endtask

	// On a 2x2 grid the exit is the top right cell; the start sits on it.
	task automatic test_start_on_exit();
		send_cell(CHAR_WALL, 1'b0);
		send_cell(CHAR_START, 1'b0);
		send_cell(CHAR_OPEN, 1'b0);
		send_cell(CHAR_OPEN, 1'b1);
		drain_results();
	endtask

	// Saturated dimensions: zero rows reads as two, giving a 2x3 grid whose path has to
	// go down, right twice and back up. Two extra cells, one of them a start, lie past
	// the grid and must be dropped. Then the opposite extremes, 127 rows and 1 column.
	task automatic test_saturated_dims();
		set_dims(0, 3);
		send_cell(CHAR_START, 1'b0);
		send_cell(CHAR_WALL, 1'b0);
		send_cell(CHAR_OPEN, 1'b0);
		send_cell(CHAR_OPEN, 1'b0);
		send_cell(CHAR_OPEN, 1'b0);
		send_cell(CHAR_OPEN, 1'b0);
		send_cell(CHAR_START, 1'b0);
		send_cell(CHAR_OPEN, 1'b1);
		drain_results();
		set_dims(127, 1);
		send_cell(CHAR_START, 1'b0);
		send_cell(CHAR_OPEN, 1'b1);
		drain_results();
	endtask

	// The grid shrinks while a maze is half loaded, so the start ends up outside it.
	// The closing cell lies past the new grid as well and is dropped.
	task automatic test_start_outside_grid();
		set_dims(3, 3);
		repeat (4) send_cell(CHAR_OPEN, 1'b0);
		send_cell(CHAR_START, 1'b0);
		drain_results();
		set_dims(2, 2);
		send_cell(CHAR_OPEN, 1'b1);
		drain_results();
	endtask

	// The result side holds off for a long stretch while small mazes keep coming
	// back to back, so the block has to stall its input stream.
	task automatic test_result_backpressure();
		set_dims(2, 2);
		sender_no_gaps = 1'b1;
		hold_request <= LONG_HOLD;
		repeat (8) send_maze(2, 2, MAZE_NORMAL);
		sender_no_gaps = 1'b0;
		drain_results();
	endtask

	// Phases of one to four random mazes under one setting of the dimensions. Most
	// grids are small; a few are long and thin, and a few use the full 64x64 grid but
	// load only its first rows.
	task automatic test_random_mazes();
		int         cell_base, roll, rows, cols, count;
		maze_kind_t kind;
		cell_base = cells_sent;
		while (cells_sent - cell_base < RANDOM_CELLS) begin
			drain_results();
			roll = $urandom_range(99);
			if (roll < 80) begin
				rows = $urandom_range(2, 5);
				cols = $urandom_range(2, 5);
			end else if (roll < 85) begin
				rows = $urandom_range(2, 3);
				cols = $urandom_range(20, MAX_COLS);
			end else if (roll < 90) begin
				rows = $urandom_range(20, MAX_ROWS);
				cols = $urandom_range(2, 3);
			end else begin
				rows = MAX_ROWS;
				cols = MAX_COLS;
			end
			set_dims(encode_dim(rows), encode_dim(cols));
			sender_no_gaps = ($urandom_range(4) == 0);
			sink_no_gaps = ($urandom_range(4) == 0);
			count = (rows * cols > 400) ? 1 : $urandom_range(1, 4);
			repeat (count) begin
				roll = $urandom_range(99);
				if (rows * cols > 400 || (roll >= 86 && roll < 94))
					kind = MAZE_SHORT;
				else if (roll < 70)
					kind = MAZE_NORMAL;
				else if (roll < 78)
					kind = MAZE_NO_START;
				else if (roll < 86)
					kind = MAZE_TWO_STARTS;
				else
					kind = MAZE_OVERFULL;
				send_maze(rows, cols, kind);
			end
		end
		sender_no_gaps = 1'b0;
		sink_no_gaps = 1'b0;
	endtask

	// Result side: every transaction is compared with the oldest predicted outcome.
	// The ready toggles in random runs, and a hold request from a test forces it low
	// for the requested number of cycles.
	initial begin : result_sink
		outcome_t want;
		int       hold_left, run_left;
		hold_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (outcomes_due.size() == 0) begin
					$error("result with no search pending: tdata %h", m_axis_tdata);
					err_count++;
				end else begin
					want = outcomes_due.pop_front();
					if (m_axis_tdata[1:0] !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status,
							m_axis_tdata[1:0]);
						err_count++;
					end
					if (m_axis_tdata[14:2] !== want.steps) begin
						$error("steps: expected %0d, actual %0d", want.steps,
							m_axis_tdata[14:2]);
						err_count++;
					end
				end
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request <= 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				m_axis_tready <= sink_no_gaps || ($urandom_range(99) < 70);
				run_left = pick_gap();
			end
		end
	end

	// Main sequence: reset once, then the directed tests, the long stall and the
	// random mazes, and finally the verdict once every outcome has been checked.
	initial begin : main_sequence
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_dims();
		test_no_start();
		test_start_on_exit();
		test_saturated_dims();
		test_start_outside_grid();
		test_result_backpressure();
		test_random_mazes();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (outcomes_due.size() == 0 && err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Safety net against a hung handshake; far beyond the slowest correct run.
	initial begin : watchdog
		#10ms;
		$display("simulation failed");
		$finish;
	end

endmodule
